FILE: src/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg - shared types and constants of the policy rule tokenizer
// token kinds, queue record layout, character codes and sizes
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam int POS_W       = 16;  // position counter, wraps
  localparam int LEN_W       = 12;  // token length, saturates
  localparam int FIFO_DEPTH  = 4;   // records between scanner and emitter, power of two
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(256);

  localparam logic [7:0] CHR_END    = 8'h00;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_LPAREN = 8'h28;
  localparam logic [7:0] CHR_RPAREN = 8'h29;
  localparam logic [7:0] CHR_COMMA  = 8'h2C;
  localparam logic [7:0] CHR_DASH   = 8'h2D;
  localparam logic [7:0] CHR_DOT    = 8'h2E;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_ONE    = 8'h31;
  localparam logic [7:0] CHR_NINE   = 8'h39;
  localparam logic [7:0] CHR_COLON  = 8'h3A;
  localparam logic [7:0] CHR_LT     = 8'h3C;
  localparam logic [7:0] CHR_EQ     = 8'h3D;
  localparam logic [7:0] CHR_GT     = 8'h3E;
  localparam logic [7:0] CHR_AT     = 8'h40;
  localparam logic [7:0] CHR_UC_A   = 8'h41;
  localparam logic [7:0] CHR_UC_Z   = 8'h5A;
  localparam logic [7:0] CHR_LC_A   = 8'h61;
  localparam logic [7:0] CHR_LC_Z   = 8'h7A;

  typedef enum logic [3:0] {
    KIND_UNKNOWN    = 4'd0,
    KIND_LPAREN     = 4'd1,
    KIND_RPAREN     = 4'd2,
    KIND_COMMA      = 4'd3,
    KIND_NUMBER     = 4'd4,
    KIND_STRING     = 4'd5,
    KIND_IDENT      = 4'd6,
    KIND_DOTTED     = 4'd7,
    KIND_COLON_DASH = 4'd8,
    KIND_LT         = 4'd9,
    KIND_LE         = 4'd10,
    KIND_GT         = 4'd11,
    KIND_GE         = 4'd12,
    KIND_EQ         = 4'd13,
    KIND_END        = 4'd14
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  start;
    logic [LEN_W-1:0]  len;
  } tok_t;

  // tokens caused by one character; tok0 always valid, tok1 only when two is set
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } rec_t;

endpackage

FILE: src/prt_scan.sv
// ----------------------------------------------------------------------------
// prt_scan - scanner front end
// takes one character per beat, updates the scanner mode and pending token,
// and writes the tokens this character causes as one record into the queue
// ----------------------------------------------------------------------------
module prt_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,
  input  logic [7:0]                char_code,
  input  logic [prt_pkg::LEN_W-1:0] max_len,
  output logic                      rec_push,
  output prt_pkg::rec_t             rec
);
  import prt_pkg::*;

  typedef enum logic [8:0] {
    MODE_IDLE     = 9'b000000001,
    MODE_NUMBER   = 9'b000000010,
    MODE_IDENT    = 9'b000000100,
    MODE_STRING   = 9'b000001000,
    MODE_AFTER_LT = 9'b000010000,
    MODE_AFTER_GT = 9'b000100000,
    MODE_AFTER_EQ = 9'b001000000,
    MODE_AFTER_CO = 9'b010000000,
    MODE_DRAIN    = 9'b100000000
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pstart_r, pstart_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic             dot_r, dot_nxt;
  logic             at_r, at_nxt;

  logic is_letter, is_digit, is_lead_digit;
  logic [LEN_W:0]   grown;
  logic             grow_fail;
  logic [LEN_W-1:0] grown_sat;

  // token-start scan of the current character
  logic             ix_vld;
  tok_t             ix_tok;
  mode_t            ix_mode;
  logic [POS_W-1:0] ix_pstart;
  logic [LEN_W-1:0] ix_plen;
  logic             ix_dot, ix_at;

  logic a_vld, b_vld, use_idle;
  tok_t a_tok, b_tok;

  assign is_letter     = (char_code >= CHR_LC_A && char_code <= CHR_LC_Z) ||
                         (char_code >= CHR_UC_A && char_code <= CHR_UC_Z);
  assign is_digit      = char_code >= CHR_ZERO && char_code <= CHR_NINE;
  assign is_lead_digit = char_code >= CHR_ONE && char_code <= CHR_NINE;

  // one more character on the pending token
  assign grown     = {1'b0, plen_r} + (LEN_W+1)'(1);
  assign grow_fail = grown > {1'b0, max_len};
  assign grown_sat = grown[LEN_W] ? {LEN_W{1'b1}} : grown[LEN_W-1:0];

  always_comb begin
    ix_vld    = 1'b0;
    ix_tok    = '{kind: KIND_UNKNOWN, start: pos_r, len: LEN_W'(1)};
    ix_mode   = MODE_IDLE;
    ix_pstart = pstart_r;
    ix_plen   = plen_r;
    ix_dot    = dot_r;
    ix_at     = at_r;
    case (char_code)
      CHR_SPACE, CHR_TAB: begin
      end
      CHR_COMMA: begin
        ix_vld      = 1'b1;
        ix_tok.kind = KIND_COMMA;
      end
      CHR_LPAREN: begin
        ix_vld      = 1'b1;
        ix_tok.kind = KIND_LPAREN;
      end
      CHR_RPAREN: begin
        ix_vld      = 1'b1;
        ix_tok.kind = KIND_RPAREN;
      end
      CHR_LT, CHR_GT, CHR_EQ, CHR_COLON, CHR_QUOTE: begin
        ix_pstart = pos_r;
        ix_plen   = '0;
        ix_dot    = 1'b0;
        ix_at     = 1'b0;
        if (char_code == CHR_LT) begin
          ix_mode = MODE_AFTER_LT;
        end else if (char_code == CHR_GT) begin
          ix_mode = MODE_AFTER_GT;
        end else if (char_code == CHR_EQ) begin
          ix_mode = MODE_AFTER_EQ;
        end else if (char_code == CHR_COLON) begin
          ix_mode = MODE_AFTER_CO;
        end else begin
          // string content starts after the quote
          ix_mode   = MODE_STRING;
          ix_pstart = pos_r + POS_W'(1);
        end
      end
      default: begin
        if (is_letter || char_code == CHR_AT || is_lead_digit) begin
          ix_pstart = pos_r;
          ix_plen   = LEN_W'(1);
          ix_dot    = 1'b0;
          ix_at     = char_code == CHR_AT;
          // a zero limit rejects even a single character
          if (max_len == '0) begin
            ix_vld  = 1'b1;
            ix_mode = MODE_DRAIN;
          end else begin
            ix_mode = is_lead_digit ? MODE_NUMBER : MODE_IDENT;
          end
        end else begin
          ix_vld  = 1'b1;
          ix_mode = MODE_DRAIN;
        end
      end
    endcase
  end

  always_comb begin
    a_vld      = 1'b0;
    a_tok      = '{kind: KIND_UNKNOWN, start: pstart_r, len: plen_r};
    b_vld      = 1'b0;
    b_tok      = '{kind: KIND_END, start: pos_r, len: '0};
    use_idle   = 1'b0;
    mode_nxt   = mode_r;
    pos_nxt    = pos_r + POS_W'(1);
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    dot_nxt    = dot_r;
    at_nxt     = at_r;
    if (char_code == CHR_END) begin
      // flush the pending token, then the end token
      b_vld      = 1'b1;
      mode_nxt   = MODE_IDLE;
      pos_nxt    = '0;
      pstart_nxt = '0;
      plen_nxt   = '0;
      dot_nxt    = 1'b0;
      at_nxt     = 1'b0;
      case (mode_r)
        MODE_NUMBER: begin
          a_vld      = 1'b1;
          a_tok.kind = KIND_NUMBER;
        end
        MODE_IDENT: begin
          a_vld      = 1'b1;
          a_tok.kind = dot_r ? KIND_DOTTED : KIND_IDENT;
        end
        MODE_STRING: begin
          a_vld = 1'b1;
        end
        MODE_AFTER_LT: begin
          a_vld = 1'b1;
          a_tok = '{kind: KIND_LT, start: pstart_r, len: LEN_W'(1)};
        end
        MODE_AFTER_GT: begin
          a_vld = 1'b1;
          a_tok = '{kind: KIND_GT, start: pstart_r, len: LEN_W'(1)};
        end
        MODE_AFTER_EQ, MODE_AFTER_CO: begin
          a_vld = 1'b1;
          a_tok = '{kind: KIND_UNKNOWN, start: pstart_r, len: LEN_W'(1)};
        end
        default: begin
        end
      endcase
    end else begin
      case (mode_r)
        MODE_NUMBER: begin
          if (is_digit) begin
            if (grow_fail) begin
              a_vld    = 1'b1;
              a_tok    = '{kind: KIND_UNKNOWN, start: pstart_r, len: grown_sat};
              mode_nxt = MODE_DRAIN;
            end else begin
              plen_nxt = grown[LEN_W-1:0];
            end
          end else begin
            a_vld      = 1'b1;
            a_tok.kind = KIND_NUMBER;
            use_idle   = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_letter || is_digit || char_code == CHR_DOT || char_code == CHR_AT) begin
            if ((char_code == CHR_DOT && dot_r) || (char_code == CHR_AT && at_r) ||
                grow_fail) begin
              a_vld    = 1'b1;
              a_tok    = '{kind: KIND_UNKNOWN, start: pstart_r, len: grown_sat};
              mode_nxt = MODE_DRAIN;
            end else begin
              plen_nxt = grown[LEN_W-1:0];
            end
            if (char_code == CHR_DOT) dot_nxt = 1'b1;
            if (char_code == CHR_AT) at_nxt = 1'b1;
          end else begin
            a_vld      = 1'b1;
            a_tok.kind = dot_r ? KIND_DOTTED : KIND_IDENT;
            use_idle   = 1'b1;
          end
        end
        MODE_STRING: begin
          if (char_code == CHR_QUOTE) begin
            a_vld      = 1'b1;
            a_tok.kind = KIND_STRING;
            mode_nxt   = MODE_IDLE;
          end else if (grow_fail) begin
            a_vld    = 1'b1;
            a_tok    = '{kind: KIND_UNKNOWN, start: pstart_r, len: grown_sat};
            mode_nxt = MODE_DRAIN;
          end else begin
            plen_nxt = grown[LEN_W-1:0];
          end
        end
        MODE_AFTER_LT, MODE_AFTER_GT: begin
          a_vld = 1'b1;
          if (char_code == CHR_EQ) begin
            a_tok    = '{kind: (mode_r == MODE_AFTER_LT) ? KIND_LE : KIND_GE,
                         start: pstart_r, len: LEN_W'(2)};
            mode_nxt = MODE_IDLE;
          end else begin
            a_tok    = '{kind: (mode_r == MODE_AFTER_LT) ? KIND_LT : KIND_GT,
                         start: pstart_r, len: LEN_W'(1)};
            use_idle = 1'b1;
          end
        end
        MODE_AFTER_EQ: begin
          a_vld = 1'b1;
          if (char_code == CHR_EQ) begin
            a_tok    = '{kind: KIND_EQ, start: pstart_r, len: LEN_W'(2)};
            mode_nxt = MODE_IDLE;
          end else begin
            a_tok    = '{kind: KIND_UNKNOWN, start: pstart_r, len: LEN_W'(2)};
            mode_nxt = MODE_DRAIN;
          end
        end
        MODE_AFTER_CO: begin
          a_vld = 1'b1;
          if (char_code == CHR_DASH) begin
            a_tok    = '{kind: KIND_COLON_DASH, start: pstart_r, len: LEN_W'(2)};
            mode_nxt = MODE_IDLE;
          end else begin
            a_tok    = '{kind: KIND_UNKNOWN, start: pstart_r, len: LEN_W'(2)};
            mode_nxt = MODE_DRAIN;
          end
        end
        MODE_DRAIN: begin
        end
        default: begin
          use_idle = 1'b1;
        end
      endcase
      if (use_idle) begin
        b_vld      = ix_vld;
        b_tok      = ix_tok;
        mode_nxt   = ix_mode;
        pstart_nxt = ix_pstart;
        plen_nxt   = ix_plen;
        dot_nxt    = ix_dot;
        at_nxt     = ix_at;
      end
    end
  end

  assign rec_push = acc && (a_vld || b_vld);
  assign rec.two  = a_vld && b_vld;
  assign rec.tok0 = a_vld ? a_tok : b_tok;
  assign rec.tok1 = b_tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      pstart_r <= '0;
      plen_r   <= '0;
      dot_r    <= 1'b0;
      at_r     <= 1'b0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      dot_r    <= dot_nxt;
      at_r     <= at_nxt;
    end
  end

endmodule

FILE: src/prt_fifo.sv
// ----------------------------------------------------------------------------
// prt_fifo - record queue
// short queue of token records between the scanner and the emitter
// ----------------------------------------------------------------------------
module prt_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  prt_pkg::rec_t wr_rec,
  input  logic          pop,
  output prt_pkg::rec_t rd_rec,
  output logic          full,
  output logic          nonempty
);
  import prt_pkg::*;

  rec_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == FIFO_CNT_W'(FIFO_DEPTH);
  assign nonempty = cnt_r != '0;
  assign rd_rec   = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + FIFO_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - FIFO_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: src/prt_emit.sv
// ----------------------------------------------------------------------------
// prt_emit - result back end
// holds one record and hands out its one or two tokens, one per beat
// ----------------------------------------------------------------------------
module prt_emit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  prt_pkg::rec_t             fifo_rec,
  input  logic                      fifo_nonempty,
  output logic                      fifo_pop,
  input  logic                      pop,
  output logic                      empty,
  output logic [3:0]                token_kind,
  output logic [prt_pkg::POS_W-1:0] token_start,
  output logic [prt_pkg::LEN_W-1:0] token_length,
  output logic                      last_of_run
);
  import prt_pkg::*;

  rec_t rec_r;
  logic vld_r, vld_nxt;
  logic sel_r, sel_nxt;
  logic take, more;
  tok_t cur;

  assign take = pop && vld_r;
  assign more = rec_r.two && !sel_r;  // second token still to go

  assign fifo_pop = fifo_nonempty && (!vld_r || (take && !more));

  always_comb begin
    vld_nxt = vld_r;
    sel_nxt = sel_r;
    if (fifo_pop) begin
      vld_nxt = 1'b1;
      sel_nxt = 1'b0;
    end else if (take && more) begin
      sel_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  assign cur          = sel_r ? rec_r.tok1 : rec_r.tok0;
  assign empty        = !vld_r;
  assign token_kind   = cur.kind;
  assign token_start  = cur.start;
  assign token_length = cur.len;
  assign last_of_run  = !more;

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      rec_r <= fifo_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sel_r <= sel_nxt;
    end
  end

endmodule

FILE: src/policy_rule_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// policy_rule_tokenizer_unit - streaming tokenizer for policy rule text
// one character per beat in, tokens (kind, start, length) out
// ----------------------------------------------------------------------------
// Characters go in one per beat through push/full; byte 0 ends a string and
// always produces an end token (after any pending token) and restarts the
// position count at 0. Tokens come out one per beat through empty/pop, with
// last_of_run marking the last token caused by a character. The scanner takes
// a character every clock while full is low; full rises only when the
// four-record queue between scanner and emitter is full. A record of two
// tokens is handed out one token per pop, a record of one token in a single
// pop, so one character per clock is sustained while the results are
// drained every clock and characters cause no more than one token each on
// average; two-token characters back the queue up until full stalls the input.
// A token reaches the result ports through the queue and then the emitter's
// record register. max_token_length is written through cfg_valid/cfg_data
// (ready is always high) and must only be changed while the block is idle; it
// resets to 256.
// ----------------------------------------------------------------------------
module policy_rule_tokenizer_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  // character channel
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                in_char_code,
  // token channel
  output logic                      empty,
  input  logic                      pop,
  output logic [3:0]                out_token_kind,
  output logic [prt_pkg::POS_W-1:0] out_token_start,
  output logic [prt_pkg::LEN_W-1:0] out_token_length,
  output logic                      out_last_of_run,
  // max token length register
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [prt_pkg::LEN_W-1:0] cfg_data
);
  import prt_pkg::*;

  logic [LEN_W-1:0] max_len_r;
  logic             acc;
  logic             rec_push;
  rec_t             rec_in;
  rec_t             rec_out;
  logic             fifo_full;
  logic             fifo_nonempty;
  logic             fifo_pop;

  // a character is taken whenever the queue has room for its record
  assign full      = fifo_full;
  assign acc       = push && !fifo_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      max_len_r <= cfg_data;
    end
  end

  // front: mode, position and pending token; at most one record per character
  prt_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .char_code (in_char_code),
    .max_len   (max_len_r),
    .rec_push  (rec_push),
    .rec       (rec_in)
  );

  // decouples the scanner from result back pressure
  prt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .wr_rec   (rec_in),
    .pop      (fifo_pop),
    .rd_rec   (rec_out),
    .full     (fifo_full),
    .nonempty (fifo_nonempty)
  );

  // back: splits a record into its token beats
  prt_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .fifo_rec      (rec_out),
    .fifo_nonempty (fifo_nonempty),
    .fifo_pop      (fifo_pop),
    .pop           (pop),
    .empty         (empty),
    .token_kind    (out_token_kind),
    .token_start   (out_token_start),
    .token_length  (out_token_length),
    .last_of_run   (out_last_of_run)
  );

  // result side comes out of reset with nothing to offer
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result port not empty after reset");

  // an end byte always leaves a record in the queue
  a_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_char_code == CHR_END) |=> fifo_nonempty)
    else $error("end byte produced no record");

  // the end token closes its run
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_token_kind == KIND_END) |-> out_last_of_run)
    else $error("end token not last of run");

endmodule
